/* sv/ctwa_pkg.sv */
// ----------------------------------------------------------------------------
// ctwa_pkg
// Shared types, widths and codes for the client table with aging.
// ----------------------------------------------------------------------------
package ctwa_pkg;

  // default table size
  localparam int TABLE_ENTRIES_DEF = 8;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // operation codes
  localparam logic OP_DISCOVERY = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UPDATED = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADDED   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FULL    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_INTERVAL = 8'd1;

  // register reset values
  localparam logic [TIME_W-1:0] CLIENT_TIMEOUT_RST = 32'd30000;
  localparam logic [TIME_W-1:0] SWEEP_INTERVAL_RST = 32'd10000;

  // one stored table entry
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;   // a equals b
    logic gt;   // (a - b) mod 2^32 exceeds limit
  } cmp_res_t;

endpackage

/* sv/ctwa_if.sv */
// ----------------------------------------------------------------------------
// ctwa_if
// Valid/ready channels of the client table: input word, result word and
// configuration write.
// ----------------------------------------------------------------------------
interface ctwa_in_if
  import ctwa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] client_address;
  logic [PORT_W-1:0] client_port;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, operation, client_address, client_port, now_ms,
                  input ready);
  modport sink   (input valid, operation, client_address, client_port, now_ms,
                  output ready);
endinterface

interface ctwa_out_if
  import ctwa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic                swept;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  client_count;

  modport source (output valid, action, slot, swept, removed_count, client_count,
                  input ready);
  modport sink   (input valid, action, slot, swept, removed_count, client_count,
                  output ready);
endinterface

interface ctwa_cfg_if
  import ctwa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ctwa_ram.sv */
// ----------------------------------------------------------------------------
// ctwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/ctwa_cmp.sv */
// ----------------------------------------------------------------------------
// ctwa_cmp
// Shared compare unit: equality for address lookup, wrapping age against a
// limit for the sweep decision and for entry expiry.
// ----------------------------------------------------------------------------
module ctwa_cmp
  import ctwa_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic [TIME_W-1:0] limit,
  output cmp_res_t          res
);

  logic [TIME_W-1:0] diff;

  // wrapping difference, compared without sign
  always_comb begin
    diff   = a - b;
    res.eq = (a == b);
    res.gt = (diff > limit);
  end

endmodule

/* sv/client_table_with_aging_core.sv */
// ----------------------------------------------------------------------------
// client_table_with_aging_core
// Client table with address lookup, lowest-free-slot insert and timed expiry.
// ----------------------------------------------------------------------------
// One word is handled at a time. Entries live in a RAM with one write and
// one read port and a registered read, so every entry visit has a read step,
// then a compare step in the shared compare unit. A tick goes straight to
// the sweep decision. A discovery first runs the lookup (a hit ends the
// lookup early) and the entry write, then the sweep decision. A sweep visits
// every entry. The result then loads into the result register once that
// register is free. The input is not ready while a word is in work. The
// result register holds its word until taken. Configuration writes are
// taken at any time and should land only while the block is idle.
// Address, port and last-seen contents are undefined until written; active
// marks, the entry count and the last sweep time clear on reset.
module client_table_with_aging_core
  import ctwa_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ctwa_in_if.sink    item,
  ctwa_out_if.source result,
  ctwa_cfg_if.sink   cfg
);

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MRD   = 3'd1;
  localparam logic [2:0] S_MCMP  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SWCHK = 3'd4;
  localparam logic [2:0] S_SRD   = 3'd5;
  localparam logic [2:0] S_SCMP  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] st;

  // configuration registers
  logic [TIME_W-1:0] client_timeout;
  logic [TIME_W-1:0] sweep_interval;

  // table state
  logic [TABLE_ENTRIES-1:0] active;
  logic [CNT_W-1:0]         count;
  logic [TIME_W-1:0]        last_sweep;

  // latched input word
  logic [ADDR_W-1:0] addr;
  logic [PORT_W-1:0] port;
  logic [TIME_W-1:0] now;

  // scan state
  logic [IDX_W-1:0]    idx;
  logic                found;
  logic                free_ok;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    slot_idx;
  logic [ACTION_W-1:0] action;
  logic                swept;
  logic [CNT_W-1:0]    removed;

  // output register
  logic                out_valid;
  logic [ACTION_W-1:0] out_action;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_swept;
  logic [COUNT_W-1:0]  out_removed;
  logic [COUNT_W-1:0]  out_count;

  // RAM and compare unit hookup
  logic                ram_we;
  logic [IDX_W-1:0]    ram_wr_addr;
  entry_t              ram_wr_entry;
  logic [ENTRY_W-1:0]  ram_rd_data;
  entry_t              rd_entry;
  logic [TIME_W-1:0]   cmp_a;
  logic [TIME_W-1:0]   cmp_b;
  logic [TIME_W-1:0]   cmp_limit;
  cmp_res_t            cmp_res;
  logic                hit;
  logic                expire;

  // widened views for masking to port widths
  logic [IDX_W+SLOT_W-1:0]   slot_ext;
  logic [CNT_W+COUNT_W-1:0]  removed_ext;
  logic [CNT_W+COUNT_W-1:0]  count_ext;

  assign item.ready = (st == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid         = out_valid;
  assign result.action        = out_action;
  assign result.slot          = out_slot;
  assign result.swept         = out_swept;
  assign result.removed_count = out_removed;
  assign result.client_count  = out_count;

  assign rd_entry    = entry_t'(ram_rd_data);
  assign slot_ext    = {{SLOT_W{1'b0}}, slot_idx};
  assign removed_ext = {{COUNT_W{1'b0}}, removed};
  assign count_ext   = {{COUNT_W{1'b0}}, count};

  // entry hits and expiries, gated by the active mark
  assign hit    = active[idx] & cmp_res.eq;
  assign expire = active[idx] & cmp_res.gt;

  // entry write on update or insert
  always_comb begin
    ram_we               = (st == S_WR) && (found || free_ok);
    ram_wr_addr          = found ? slot_idx : free_idx;
    ram_wr_entry.address   = addr;
    ram_wr_entry.port      = port;
    ram_wr_entry.last_seen = now;
  end

  // steer the shared compare unit
  always_comb begin
    unique case (st)
      S_MCMP: begin
        cmp_a     = addr;
        cmp_b     = rd_entry.address;
        cmp_limit = sweep_interval;
      end
      S_SCMP: begin
        cmp_a     = now;
        cmp_b     = rd_entry.last_seen;
        cmp_limit = client_timeout;
      end
      default: begin
        cmp_a     = now;
        cmp_b     = last_sweep;
        cmp_limit = sweep_interval;
      end
    endcase
  end

  ctwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_addr (idx),
    .rd_data (ram_rd_data)
  );

  ctwa_cmp u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .limit (cmp_limit),
    .res   (cmp_res)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      client_timeout <= CLIENT_TIMEOUT_RST;
      sweep_interval <= SWEEP_INTERVAL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CLIENT_TIMEOUT: client_timeout <= cfg.data;
        REG_SWEEP_INTERVAL: sweep_interval <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer: lookup, write, sweep decision, expiry scan, result
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      active     <= '0;
      count      <= '0;
      last_sweep <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop the result word once taken, unless a new one loads now
      if (out_valid && result.ready && st != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (item.valid) begin
            addr     <= item.client_address;
            port     <= item.client_port;
            now      <= item.now_ms;
            idx      <= '0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            free_idx <= '0;
            slot_idx <= '0;
            action   <= ACT_NONE;
            swept    <= 1'b0;
            removed  <= '0;
            st       <= (item.operation == OP_DISCOVERY) ? S_MRD : S_SWCHK;
          end
        end
        S_MRD: begin
          st <= S_MCMP;
        end
        S_MCMP: begin
          if (hit) begin
            found    <= 1'b1;
            slot_idx <= idx;
            st       <= S_WR;
          end else begin
            // remember the lowest free slot
            if (!active[idx] && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= idx;
            end
            if (idx == LAST_IDX) begin
              st <= S_WR;
            end else begin
              idx <= idx + 1'b1;
              st  <= S_MRD;
            end
          end
        end
        S_WR: begin
          if (found) begin
            action <= ACT_UPDATED;
          end else if (free_ok) begin
            action           <= ACT_ADDED;
            slot_idx         <= free_idx;
            active[free_idx] <= 1'b1;
            count            <= count + 1'b1;
          end else begin
            action <= ACT_FULL;
          end
          st <= S_SWCHK;
        end
        S_SWCHK: begin
          if (cmp_res.gt) begin
            swept      <= 1'b1;
            last_sweep <= now;
            idx        <= '0;
            st         <= S_SRD;
          end else begin
            st <= S_OUT;
          end
        end
        S_SRD: begin
          st <= S_SCMP;
        end
        S_SCMP: begin
          if (expire) begin
            active[idx] <= 1'b0;
            count       <= count - 1'b1;
            removed     <= removed + 1'b1;
          end
          if (idx == LAST_IDX) begin
            st <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            st  <= S_SRD;
          end
        end
        S_OUT: begin
          // load the result word when the register is free
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_action  <= action;
            out_slot    <= (action == ACT_UPDATED || action == ACT_ADDED) ?
                           slot_ext[SLOT_W-1:0] : '0;
            out_swept   <= swept;
            out_removed <= removed_ext[COUNT_W-1:0];
            out_count   <= count_ext[COUNT_W-1:0];
            st          <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/ctwa_checker.sv */
// ----------------------------------------------------------------------------
// ctwa_checker
// Port-level checks of the client table, bound to the top level.
// ----------------------------------------------------------------------------
module ctwa_checker
  import ctwa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic [ACTION_W-1:0] action,
  input logic [SLOT_W-1:0]   slot,
  input logic                swept,
  input logic [COUNT_W-1:0]  removed_count,
  input logic [COUNT_W-1:0]  client_count
);

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after an accepted word");

  // ticks and drops carry no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (action == ACT_NONE || action == ACT_FULL) |-> slot == '0)
    else $error("slot set on tick or dropped discovery");

  // nothing removed without a sweep
  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    result_valid && !swept |-> removed_count == '0)
    else $error("entries removed without a sweep");

  // a fresh entry never expires on the word that added it, so with nothing removed the count is not zero
  a_added_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && action == ACT_ADDED && removed_count == '0 |-> client_count != '0)
    else $error("added entry missing from the count");

endmodule

bind client_table_with_aging_core ctwa_checker u_ctwa_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .action        (result.action),
  .slot          (result.slot),
  .swept         (result.swept),
  .removed_count (result.removed_count),
  .client_count  (result.client_count)
);
